/* rtl/hsv_to_rgb_converter_core_defines.svh */
// Assertion macros shared by the converter RTL.
`ifndef HSV_TO_RGB_CONVERTER_CORE_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked assertion with explicit clock and reset.
`define HSV2RGB_ASSERT_CLK(label, clk_sig, rstn_sig, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
        else $error("hsv2rgb assertion failed");
// Same check on the local clk and rst_n.
`define HSV2RGB_ASSERT(label, prop) \
    `HSV2RGB_ASSERT_CLK(label, clk, rst_n, prop)
`else
`define HSV2RGB_ASSERT_CLK(label, clk_sig, rstn_sig, prop)
`define HSV2RGB_ASSERT(label, prop)
`endif

`endif

/* rtl/hsv2rgb_pkg.sv */
// Types and constants shared by the HSV to RGB converter.
`default_nettype none

package hsv2rgb_pkg;

    localparam int CH_W      = 8;
    localparam int HUE_W     = 16;
    localparam int SV_W      = 16;
    localparam int NUM_CH    = 3;
    localparam int REG_IDX_W = 2;
    localparam int NUM_SECT  = 6;
    localparam int SECT_W    = 3;

    localparam int HUE_SECTION = 256;
    localparam int HUE_LIMIT   = 1536;
    localparam int SAT_MAX     = 255;
    localparam int VAL_MAX     = 255;

    // Register indexes double as channel positions.
    localparam logic [REG_IDX_W-1:0] REG_RED_LIMIT   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_GREEN_LIMIT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BLUE_LIMIT  = 2'd2;
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    localparam logic [CH_W-1:0] LIMIT_RESET = 8'hFF;

    localparam logic [SV_W-1:0]  SAT_MAX_V = SV_W'(SAT_MAX);
    localparam logic [SV_W-1:0]  VAL_MAX_V = SV_W'(VAL_MAX);
    localparam logic [HUE_W-1:0] HUE_LIM_V = HUE_W'(HUE_LIMIT);

    localparam int D_W = (HUE_SECTION > 1) ? $clog2(HUE_SECTION) : 1;

    // Exact floor division by a constant: (x * ceil(2^(N+l)/D)) >> (N+l).
    localparam int HUE_SHIFT   = HUE_W + $clog2(HUE_LIMIT);
    localparam int HUE_RECIP_W = HUE_W + 1;
    localparam int HUE_PROD_W  = HUE_W + HUE_RECIP_W;
    localparam logic [HUE_RECIP_W-1:0] HUE_RECIP = HUE_RECIP_W'(
        ((64'd1 << HUE_SHIFT) + 64'(HUE_LIMIT) - 64'd1) / 64'(HUE_LIMIT));

    localparam int RAMP_W       = D_W + CH_W;
    localparam int RAMP_SHIFT   = RAMP_W + $clog2(HUE_SECTION);
    localparam int RAMP_RECIP_W = RAMP_W + 1;
    localparam int RAMP_PROD_W  = RAMP_W + RAMP_RECIP_W;
    localparam logic [RAMP_RECIP_W-1:0] RAMP_RECIP = RAMP_RECIP_W'(
        ((64'd1 << RAMP_SHIFT) + 64'(HUE_SECTION) - 64'd1) / 64'(HUE_SECTION));

    localparam int MIX_W       = SV_W + CH_W;
    localparam int MIX_RECIP_W = MIX_W + 1;
    localparam int MIX_PROD_W  = MIX_W + MIX_RECIP_W;
    localparam int SAT_SHIFT   = MIX_W + $clog2(SAT_MAX);
    localparam logic [MIX_RECIP_W-1:0] SAT_RECIP = MIX_RECIP_W'(
        ((64'd1 << SAT_SHIFT) + 64'(SAT_MAX) - 64'd1) / 64'(SAT_MAX));
    localparam int VAL_SHIFT   = MIX_W + $clog2(VAL_MAX);
    localparam logic [MIX_RECIP_W-1:0] VAL_RECIP = MIX_RECIP_W'(
        ((64'd1 << VAL_SHIFT) + 64'(VAL_MAX) - 64'd1) / 64'(VAL_MAX));

    typedef enum logic [SECT_W-1:0] {
        SECT_RED_YEL,
        SECT_YEL_GRN,
        SECT_GRN_CYN,
        SECT_CYN_BLU,
        SECT_BLU_MAG,
        SECT_MAG_RED,
        SECT_BLACK
    } sect_t;

    typedef logic [CH_W-1:0] chan_t;
    typedef chan_t [NUM_CH-1:0] rgb_t;

    typedef struct packed {
        logic [SV_W-1:0] sat;
        logic [SV_W-1:0] val;
        logic [CH_W-1:0] alpha;
        logic            sat_full;
        logic            val_full;
    } side_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SV_W-1:0]  sat;
        logic [SV_W-1:0]  val;
        logic [CH_W-1:0]  alpha;
    } hsv_pix_t;

    typedef struct packed {
        sect_t          sect;
        logic [D_W-1:0] offs;
        side_t          side;
    } sect_pix_t;

    typedef struct packed {
        rgb_t  chan;
        side_t side;
    } chan_pix_t;

    typedef struct packed {
        rgb_t            chan;
        logic [CH_W-1:0] alpha;
    } rgb_pix_t;

endpackage

`default_nettype wire

/* rtl/hsv2rgb_in_if.sv */
// Input stream interface: one HSV color with alpha per transfer.
`default_nettype none

interface hsv2rgb_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] hue;
    logic [15:0] saturation;
    logic [15:0] brightness;
    logic [7:0]  alpha_in;

    modport source (output valid, output hue, output saturation, output brightness,
                    output alpha_in, input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    input alpha_in, output ready);
endinterface

`default_nettype wire

/* rtl/hsv2rgb_out_if.sv */
// Output stream interface: one RGB color with alpha per transfer.
`default_nettype none

interface hsv2rgb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha_out;

    modport source (output valid, output red, output green, output blue,
                    output alpha_out, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input alpha_out, output ready);
endinterface

`default_nettype wire

/* rtl/hsv2rgb_hue_unit.sv */
// Hue reduction modulo the hue limit and section/offset split, four stages.
`default_nettype none

module hsv2rgb_hue_unit
    import hsv2rgb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      hsv_valid,
    output logic      hsv_ready,
    input  hsv_pix_t  hsv_pix,
    output logic      sect_valid,
    input  logic      sect_ready,
    output sect_pix_t sect_pix
);

    logic [3:0] vld_reg;
    logic [3:0] vld_next;
    logic [3:0] adv;

    logic [HUE_PROD_W-1:0] quo_prod_a_reg;
    logic [HUE_PROD_W-1:0] quo_prod_a_next;
    logic [HUE_W-1:0]      hue_a_reg;
    side_t                 side_a_reg;
    side_t                 side_a_next;

    logic [HUE_PROD_W-1:0] quo_shift;
    logic [HUE_W-1:0]      quo;
    logic [2*HUE_W-1:0]    qlim_full;
    logic [HUE_W-1:0]      qlim_b_reg;
    logic [HUE_W-1:0]      qlim_b_next;
    logic [HUE_W-1:0]      hue_b_reg;
    side_t                 side_b_reg;

    logic [HUE_W-1:0]      h_c_reg;
    logic [HUE_W-1:0]      h_c_next;
    side_t                 side_c_reg;

    logic [HUE_W-1:0]      base;
    logic [HUE_W-1:0]      offs_full;
    sect_t                 sect_d_reg;
    sect_t                 sect_d_next;
    logic [D_W-1:0]        offs_d_reg;
    logic [D_W-1:0]        offs_d_next;
    side_t                 side_d_reg;

    // A stage advances when it is empty or the next one advances.
    always_comb
    begin
        adv[3] = !vld_reg[3] || sect_ready;
        adv[2] = !vld_reg[2] || adv[3];
        adv[1] = !vld_reg[1] || adv[2];
        adv[0] = !vld_reg[0] || adv[1];
    end

    assign vld_next   = {vld_reg[2:0], hsv_valid};
    assign hsv_ready  = adv[0];
    assign sect_valid = vld_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= (vld_next & adv) | (vld_reg & ~adv);
        end
    end

    // Stage A: reciprocal multiply for the hue quotient, clamp flags.
    always_comb
    begin
        quo_prod_a_next      = hsv_pix.hue * HUE_RECIP;
        side_a_next.sat      = hsv_pix.sat;
        side_a_next.val      = hsv_pix.val;
        side_a_next.alpha    = hsv_pix.alpha;
        side_a_next.sat_full = (hsv_pix.sat >= SAT_MAX_V);
        side_a_next.val_full = (hsv_pix.val >= VAL_MAX_V);
    end

    // Stage B: quotient times the hue limit.
    always_comb
    begin
        quo_shift   = quo_prod_a_reg >> HUE_SHIFT;
        quo         = quo_shift[HUE_W-1:0];
        qlim_full   = quo * HUE_LIM_V;
        qlim_b_next = qlim_full[HUE_W-1:0];
    end

    // Stage C: remainder.
    assign h_c_next = hue_b_reg - qlim_b_reg;

    // Stage D: thresholds rise with k, so the last hit gives the section.
    always_comb
    begin
        sect_d_next = SECT_RED_YEL;
        base        = '0;
        for (int k = 1; k <= NUM_SECT; k++)
        begin
            if ({1'b0, h_c_reg} >= (HUE_W + 1)'(k * HUE_SECTION))
            begin
                sect_d_next = sect_t'(SECT_W'(k));
                base        = HUE_W'(k * HUE_SECTION);
            end
        end
        offs_full   = h_c_reg - base;
        offs_d_next = offs_full[D_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            quo_prod_a_reg <= quo_prod_a_next;
            hue_a_reg      <= hsv_pix.hue;
            side_a_reg     <= side_a_next;
        end
        if (adv[1])
        begin
            qlim_b_reg <= qlim_b_next;
            hue_b_reg  <= hue_a_reg;
            side_b_reg <= side_a_reg;
        end
        if (adv[2])
        begin
            h_c_reg    <= h_c_next;
            side_c_reg <= side_b_reg;
        end
        if (adv[3])
        begin
            sect_d_reg <= sect_d_next;
            offs_d_reg <= offs_d_next;
            side_d_reg <= side_c_reg;
        end
    end

    assign sect_pix.sect = sect_d_reg;
    assign sect_pix.offs = offs_d_reg;
    assign sect_pix.side = side_d_reg;

endmodule

`default_nettype wire

/* rtl/hsv2rgb_ramp_unit.sv */
// Section ramp: offset times limit over the section length, three stages.
`default_nettype none

module hsv2rgb_ramp_unit
    import hsv2rgb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  rgb_t      lim,
    input  logic      sect_valid,
    output logic      sect_ready,
    input  sect_pix_t sect_pix,
    output logic      chan_valid,
    input  logic      chan_ready,
    output chan_pix_t chan_pix
);

    logic [2:0] vld_reg;
    logic [2:0] vld_next;
    logic [2:0] adv;

    chan_t               lim_sel;
    logic [RAMP_W-1:0]   prod_a_reg;
    logic [RAMP_W-1:0]   prod_a_next;
    chan_t               lim_a_reg;
    sect_t               sect_a_reg;
    side_t               side_a_reg;

    logic [RAMP_PROD_W-1:0] ramp_prod;
    logic [RAMP_PROD_W-1:0] ramp_shift;
    chan_t               ramp_b_reg;
    chan_t               ramp_b_next;
    chan_t               lim_b_reg;
    sect_t               sect_b_reg;
    side_t               side_b_reg;

    chan_t               fall;
    rgb_t                chan_c_reg;
    rgb_t                chan_c_next;
    side_t               side_c_reg;

    always_comb
    begin
        adv[2] = !vld_reg[2] || chan_ready;
        adv[1] = !vld_reg[1] || adv[2];
        adv[0] = !vld_reg[0] || adv[1];
    end

    assign vld_next   = {vld_reg[1:0], sect_valid};
    assign sect_ready = adv[0];
    assign chan_valid = vld_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= (vld_next & adv) | (vld_reg & ~adv);
        end
    end

    // Stage A: pick the ramping channel's limit and scale the offset.
    always_comb
    begin
        case (sect_pix.sect)
            SECT_RED_YEL, SECT_CYN_BLU: lim_sel = lim[CH_GREEN];
            SECT_YEL_GRN, SECT_BLU_MAG: lim_sel = lim[CH_RED];
            SECT_GRN_CYN, SECT_MAG_RED: lim_sel = lim[CH_BLUE];
            default:                    lim_sel = '0;
        endcase
        prod_a_next = sect_pix.offs * lim_sel;
    end

    // Stage B: divide by the section length.
    always_comb
    begin
        ramp_prod   = prod_a_reg * RAMP_RECIP;
        ramp_shift  = ramp_prod >> RAMP_SHIFT;
        ramp_b_next = ramp_shift[CH_W-1:0];
    end

    // Stage C: in each color section one channel ramps, one sits at its limit, one at zero.
    always_comb
    begin
        fall        = lim_b_reg - ramp_b_reg;
        chan_c_next = '0;
        case (sect_b_reg)
            SECT_RED_YEL:
            begin
                chan_c_next[CH_RED]   = lim[CH_RED];
                chan_c_next[CH_GREEN] = ramp_b_reg;
            end
            SECT_YEL_GRN:
            begin
                chan_c_next[CH_RED]   = fall;
                chan_c_next[CH_GREEN] = lim[CH_GREEN];
            end
            SECT_GRN_CYN:
            begin
                chan_c_next[CH_GREEN] = lim[CH_GREEN];
                chan_c_next[CH_BLUE]  = ramp_b_reg;
            end
            SECT_CYN_BLU:
            begin
                chan_c_next[CH_GREEN] = fall;
                chan_c_next[CH_BLUE]  = lim[CH_BLUE];
            end
            SECT_BLU_MAG:
            begin
                chan_c_next[CH_RED]   = ramp_b_reg;
                chan_c_next[CH_BLUE]  = lim[CH_BLUE];
            end
            SECT_MAG_RED:
            begin
                chan_c_next[CH_RED]   = lim[CH_RED];
                chan_c_next[CH_BLUE]  = fall;
            end
            default:
            begin
                chan_c_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            prod_a_reg <= prod_a_next;
            lim_a_reg  <= lim_sel;
            sect_a_reg <= sect_pix.sect;
            side_a_reg <= sect_pix.side;
        end
        if (adv[1])
        begin
            ramp_b_reg <= ramp_b_next;
            lim_b_reg  <= lim_a_reg;
            sect_b_reg <= sect_a_reg;
            side_b_reg <= side_a_reg;
        end
        if (adv[2])
        begin
            chan_c_reg <= chan_c_next;
            side_c_reg <= side_b_reg;
        end
    end

    assign chan_pix.chan = chan_c_reg;
    assign chan_pix.side = side_c_reg;

endmodule

`default_nettype wire

/* rtl/hsv2rgb_scale_unit.sv */
// Saturation blend toward the limits, then value scaling, five stages.
`default_nettype none

module hsv2rgb_scale_unit
    import hsv2rgb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  rgb_t      lim,
    input  logic      chan_valid,
    output logic      chan_ready,
    input  chan_pix_t chan_pix,
    output logic      rgb_valid,
    input  logic      rgb_ready,
    output rgb_pix_t  rgb_pix
);

    logic [4:0] vld_reg;
    logic [4:0] vld_next;
    logic [4:0] adv;

    rgb_t                              diff;
    logic [NUM_CH-1:0][MIX_W-1:0]      mix_a_reg;
    logic [NUM_CH-1:0][MIX_W-1:0]      mix_a_next;
    rgb_t                              chan_a_reg;
    side_t                             side_a_reg;

    logic [NUM_CH-1:0][MIX_PROD_W-1:0] sat_prod;
    logic [NUM_CH-1:0][MIX_PROD_W-1:0] sat_shift;
    rgb_t                              quo_b_reg;
    rgb_t                              quo_b_next;
    rgb_t                              chan_b_reg;
    side_t                             side_b_reg;

    rgb_t                              blend_c_reg;
    rgb_t                              blend_c_next;
    side_t                             side_c_reg;

    logic [NUM_CH-1:0][MIX_W-1:0]      scl_d_reg;
    logic [NUM_CH-1:0][MIX_W-1:0]      scl_d_next;
    rgb_t                              blend_d_reg;
    side_t                             side_d_reg;

    logic [NUM_CH-1:0][MIX_PROD_W-1:0] val_prod;
    logic [NUM_CH-1:0][MIX_PROD_W-1:0] val_shift;
    rgb_t                              out_e_reg;
    rgb_t                              out_e_next;
    logic [CH_W-1:0]                   alpha_e_reg;

    always_comb
    begin
        adv[4] = !vld_reg[4] || rgb_ready;
        adv[3] = !vld_reg[3] || adv[4];
        adv[2] = !vld_reg[2] || adv[3];
        adv[1] = !vld_reg[1] || adv[2];
        adv[0] = !vld_reg[0] || adv[1];
    end

    assign vld_next   = {vld_reg[3:0], chan_valid};
    assign chan_ready = adv[0];
    assign rgb_valid  = vld_reg[4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= (vld_next & adv) | (vld_reg & ~adv);
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            // Stage A: distance to the limit times saturation.
            diff[c]       = lim[c] - chan_pix.chan[c];
            mix_a_next[c] = chan_pix.side.sat * diff[c];
            // Stage B: divide by the saturation maximum.
            sat_prod[c]   = mix_a_reg[c] * SAT_RECIP;
            sat_shift[c]  = sat_prod[c] >> SAT_SHIFT;
            quo_b_next[c] = sat_shift[c][CH_W-1:0];
            // Stage C: limit minus the quotient, or the channel itself at full saturation.
            blend_c_next[c] = side_b_reg.sat_full ? chan_b_reg[c] : lim[c] - quo_b_reg[c];
            // Stage D: times value.
            scl_d_next[c] = side_c_reg.val * blend_c_reg[c];
            // Stage E: divide by the value maximum, keep at full value.
            val_prod[c]   = scl_d_reg[c] * VAL_RECIP;
            val_shift[c]  = val_prod[c] >> VAL_SHIFT;
            out_e_next[c] = side_d_reg.val_full ? blend_d_reg[c] : val_shift[c][CH_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            mix_a_reg  <= mix_a_next;
            chan_a_reg <= chan_pix.chan;
            side_a_reg <= chan_pix.side;
        end
        if (adv[1])
        begin
            quo_b_reg  <= quo_b_next;
            chan_b_reg <= chan_a_reg;
            side_b_reg <= side_a_reg;
        end
        if (adv[2])
        begin
            blend_c_reg <= blend_c_next;
            side_c_reg  <= side_b_reg;
        end
        if (adv[3])
        begin
            scl_d_reg   <= scl_d_next;
            blend_d_reg <= blend_c_reg;
            side_d_reg  <= side_c_reg;
        end
        if (adv[4])
        begin
            out_e_reg   <= out_e_next;
            alpha_e_reg <= side_d_reg.alpha;
        end
    end

    assign rgb_pix.chan  = out_e_reg;
    assign rgb_pix.alpha = alpha_e_reg;

endmodule

`default_nettype wire

/* rtl/hsv_to_rgb_converter_core.sv */
// Top level of the HSV to RGB converter: limit registers and the pipeline.
`default_nettype none
`include "hsv_to_rgb_converter_core_defines.svh"

// Converts one HSV color with alpha into one RGB color per clock while the
// output is not stalled. The pipeline has twelve register stages: four for
// the hue remainder and section split, three for the ramp, five for the
// saturation blend and value scaling. The output stage is a register, and any
// empty stage lets a new item in while a finished one waits. Each division by
// a constant is an exact reciprocal multiply followed by a shift. The user is
// to write channel limits on the cfg port (0 red, 1 green, 2 blue; other
// indexes are ignored) only while no color is in flight; the block does not
// enforce this. Limits reset to full scale.

module hsv_to_rgb_converter_core
    import hsv2rgb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CH_W-1:0]      cfg_data,
    hsv2rgb_in_if.sink           hsv,
    hsv2rgb_out_if.source        rgb
);

    rgb_t      lim_reg;
    rgb_t      lim_next;

    hsv_pix_t  hsv_pix;
    logic      sect_valid;
    logic      sect_ready;
    sect_pix_t sect_pix;
    logic      chan_valid;
    logic      chan_ready;
    chan_pix_t chan_pix;
    rgb_pix_t  rgb_pix;

    always_comb
    begin
        lim_next = lim_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_RED_LIMIT:   lim_next[CH_RED]   = cfg_data;
                REG_GREEN_LIMIT: lim_next[CH_GREEN] = cfg_data;
                REG_BLUE_LIMIT:  lim_next[CH_BLUE]  = cfg_data;
                default:         lim_next = lim_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg <= {NUM_CH{LIMIT_RESET}};
        end
        else
        begin
            lim_reg <= lim_next;
        end
    end

    assign hsv_pix.hue   = hsv.hue;
    assign hsv_pix.sat   = hsv.saturation;
    assign hsv_pix.val   = hsv.brightness;
    assign hsv_pix.alpha = hsv.alpha_in;

    hsv2rgb_hue_unit u_hue (
        .clk        (clk),
        .rst_n      (rst_n),
        .hsv_valid  (hsv.valid),
        .hsv_ready  (hsv.ready),
        .hsv_pix    (hsv_pix),
        .sect_valid (sect_valid),
        .sect_ready (sect_ready),
        .sect_pix   (sect_pix)
    );

    hsv2rgb_ramp_unit u_ramp (
        .clk        (clk),
        .rst_n      (rst_n),
        .lim        (lim_reg),
        .sect_valid (sect_valid),
        .sect_ready (sect_ready),
        .sect_pix   (sect_pix),
        .chan_valid (chan_valid),
        .chan_ready (chan_ready),
        .chan_pix   (chan_pix)
    );

    hsv2rgb_scale_unit u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .lim        (lim_reg),
        .chan_valid (chan_valid),
        .chan_ready (chan_ready),
        .chan_pix   (chan_pix),
        .rgb_valid  (rgb.valid),
        .rgb_ready  (rgb.ready),
        .rgb_pix    (rgb_pix)
    );

    assign rgb.red       = rgb_pix.chan[CH_RED];
    assign rgb.green     = rgb_pix.chan[CH_GREEN];
    assign rgb.blue      = rgb_pix.chan[CH_BLUE];
    assign rgb.alpha_out = rgb_pix.alpha;

    // An empty or draining output stage frees every stage behind it.
    `HSV2RGB_ASSERT(a_ready_when_drain, (!rgb.valid || rgb.ready) |-> hsv.ready)
    // The offset into a color section stays below the section length.
    `HSV2RGB_ASSERT(a_offs_in_section, sect_valid && (sect_pix.sect != SECT_BLACK) |-> (32'(sect_pix.offs) < HUE_SECTION))
    // Nothing leaves the pipeline right after reset.
    `HSV2RGB_ASSERT(a_empty_after_reset, $rose(rst_n) |-> !rgb.valid)

endmodule

`default_nettype wire
